// ===== hw/rtl/x86_64_mov_encoder_macros.svh =====
// Assertion macros used by the checker file of the MOV encoder.
`ifndef X86_64_MOV_ENCODER_MACROS_SVH
`define X86_64_MOV_ENCODER_MACROS_SVH

// Property checked at every clock edge, masked while reset is high.
`define X86MOV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define X86MOV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/x86mov_pkg.sv =====
// Types and encoding constants shared by the MOV encoder modules.
package x86mov_pkg;

   // Number of bytes in the longest instruction (REX + B8+r + imm64).
   localparam int unsigned MAX_BYTES = 10;
   localparam int unsigned LEN_W     = 4;

   // Request mode codes.
   localparam logic [1:0] MODE_STORE = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_REG   = 2'd2;
   localparam logic [1:0] MODE_IMM   = 2'd3;

   // ModRM mod field codes.
   localparam logic [1:0] MOD_NODISP = 2'b00;
   localparam logic [1:0] MOD_DISP8  = 2'b01;
   localparam logic [1:0] MOD_DISP32 = 2'b10;
   localparam logic [1:0] MOD_DIRECT = 2'b11;

   // Opcodes and fixed bytes.
   localparam logic [7:0] OPC_MOV_STORE = 8'h89;
   localparam logic [7:0] OPC_MOV_LOAD  = 8'h8B;
   localparam logic [7:0] OPC_MOV_IMM32 = 8'hC7;
   localparam logic [7:0] OPC_MOV_IMM64 = 8'hB8;
   localparam logic [7:0] SIB_NO_INDEX  = 8'h24;

   // Low register bits that need special memory handling.
   localparam logic [2:0] RM_SIB   = 3'd4;
   localparam logic [2:0] RM_RIPBP = 3'd5;

   // One encoded instruction: byte 0 goes out first.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [LEN_W-1:0]          len;
   } enc_type;

   // REX prefix with W set.
   function automatic logic [7:0] rex_w(input logic r_hi, input logic b_hi);
      return {4'h4, 1'b1, r_hi, 1'b0, b_hi};
   endfunction

endpackage

// ===== hw/rtl/x86mov_front.sv =====
// Front end: request handshake and classification into an encoded byte record.
module x86mov_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [3:0]           req_dst_reg,
   input  logic [3:0]           req_src_reg,
   input  logic [3:0]           req_base_reg,
   input  logic signed [31:0]   req_displacement,
   input  logic signed [63:0]   req_immediate,
   input  logic                 q_full,
   output logic                 push,
   output x86mov_pkg::enc_type  enc
);

   logic [3:0]  reg_sel;
   logic        sib;
   logic        disp_zero;
   logic        disp_short;
   logic [1:0]  mod;
   logic [3:0]  disp_len;
   logic [55:0] tail;
   logic [3:0]  tail_len;
   logic [7:0]  modrm;
   logic [63:0] rest;
   logic [7:0]  rex;
   logic [7:0]  opc;
   logic [3:0]  len;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   // Memory operand pieces.
   always_comb begin
      reg_sel    = (req_mode == x86mov_pkg::MODE_STORE) ? req_src_reg : req_dst_reg;
      sib        = (req_base_reg[2:0] == x86mov_pkg::RM_SIB);
      disp_zero  = (req_displacement == 32'sd0);
      // fits in a signed byte when bits 31..7 all match
      disp_short = (req_displacement[31:7] == 25'd0) || (req_displacement[31:7] == '1);
      if (disp_zero && (req_base_reg[2:0] != x86mov_pkg::RM_RIPBP)) begin
         mod      = x86mov_pkg::MOD_NODISP;
         disp_len = 4'd0;
      end else if (disp_short) begin
         mod      = x86mov_pkg::MOD_DISP8;
         disp_len = 4'd1;
      end else begin
         mod      = x86mov_pkg::MOD_DISP32;
         disp_len = 4'd4;
      end
      tail     = sib ? {16'd0, req_displacement, x86mov_pkg::SIB_NO_INDEX}
                     : {24'd0, req_displacement};
      tail_len = {3'd0, sib} + disp_len;
   end

   // Form decode.
   always_comb begin
      unique case (req_mode) inside
         x86mov_pkg::MODE_STORE, x86mov_pkg::MODE_LOAD: begin
            rex   = x86mov_pkg::rex_w(reg_sel[3], req_base_reg[3]);
            opc   = (req_mode == x86mov_pkg::MODE_STORE) ? x86mov_pkg::OPC_MOV_STORE
                                                         : x86mov_pkg::OPC_MOV_LOAD;
            modrm = {mod, reg_sel[2:0], req_base_reg[2:0]};
            rest  = {tail, modrm};
            len   = 4'd3 + tail_len;
         end
         x86mov_pkg::MODE_REG: begin
            rex   = x86mov_pkg::rex_w(req_src_reg[3], req_dst_reg[3]);
            opc   = x86mov_pkg::OPC_MOV_STORE;
            modrm = {x86mov_pkg::MOD_DIRECT, req_src_reg[2:0], req_dst_reg[2:0]};
            rest  = {56'd0, modrm};
            len   = 4'd3;
         end
         default: begin
            rex   = x86mov_pkg::rex_w(1'b0, req_dst_reg[3]);
            modrm = {x86mov_pkg::MOD_DIRECT, 3'd0, req_dst_reg[2:0]};
            // C7 sign-extends, so only 0..7FFFFFFF may use imm32
            if (req_immediate[63:31] == 33'd0) begin
               opc  = x86mov_pkg::OPC_MOV_IMM32;
               rest = {24'd0, req_immediate[31:0], modrm};
               len  = 4'd7;
            end else begin
               opc  = x86mov_pkg::OPC_MOV_IMM64 | {5'd0, req_dst_reg[2:0]};
               rest = req_immediate;
               len  = 4'd10;
            end
         end
      endcase
   end

   assign enc.bytes = {rest, opc, rex};
   assign enc.len   = len;

endmodule

// ===== hw/rtl/x86mov_queue.sv =====
// Small FIFO of encoded records between the front and back ends.
module x86mov_queue #(
   parameter int unsigned DEPTH = 2   // 2 or more
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  x86mov_pkg::enc_type wr_data,
   output logic                full,
   input  logic                pop,
   output logic                rd_valid,
   output x86mov_pkg::enc_type rd_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   x86mov_pkg::enc_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_pop;

   assign full     = (cnt_ff == FULL_CNT);
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hw/rtl/x86mov_back.sv =====
// Back end: shifts an encoded record out one byte per transaction.
module x86mov_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  x86mov_pkg::enc_type q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last
);

   logic [x86mov_pkg::MAX_BYTES-1:0][7:0] data_ff, data_in;
   logic [x86mov_pkg::LEN_W-1:0]          left_ff, left_in;
   logic                                  take;
   logic                                  done;

   assign rsp_valid    = (left_ff != '0);
   assign rsp_out_byte = data_ff[0];
   assign rsp_last     = (left_ff == x86mov_pkg::LEN_W'(1));
   assign take         = rsp_valid && rsp_ready;
   // empty, or the final byte leaves this cycle
   assign done         = !rsp_valid || (take && rsp_last);
   assign pop          = done && q_valid;

   always_comb begin
      data_in = data_ff;
      left_in = left_ff;
      if (pop) begin
         data_in = q_data.bytes;
         left_in = q_data.len;
      end else if (take) begin
         data_in = {8'd0, data_ff[x86mov_pkg::MAX_BYTES-1:1]};
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hw/rtl/x86_64_mov_encoder.sv =====
// A record is written to the queue, then loaded into the byte shifter, before rsp shows it.
// Throughput: one byte per cycle while rsp_ready is high; a 3 to 10 byte instruction holds
// the back end until its last byte leaves; the byte channel sets the sustained request rate.
// A record queue of QUEUE_DEPTH entries lets requests be taken while bytes still drain.
// Reset (synchronous, active high) empties the queue and the byte shifter.
module x86_64_mov_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_dst_reg,
   input  logic [3:0]         req_src_reg,
   input  logic [3:0]         req_base_reg,
   input  logic signed [31:0] req_displacement,
   input  logic signed [63:0] req_immediate,
   // byte channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);

   // Front end -> queue
   logic                push;
   logic                q_full;
   x86mov_pkg::enc_type enc;

   // Queue -> back end
   logic                q_valid;
   logic                pop;
   x86mov_pkg::enc_type q_data;

   // Classify each request transaction into a complete byte record in one pass.
   x86mov_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_dst_reg      (req_dst_reg),
      .req_src_reg      (req_src_reg),
      .req_base_reg     (req_base_reg),
      .req_displacement (req_displacement),
      .req_immediate    (req_immediate),
      .q_full           (q_full),
      .push             (push),
      .enc              (enc)
   );

   // Decouples request acceptance from byte draining.
   x86mov_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_data  (enc),
      .full     (q_full),
      .pop      (pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // Registered byte output; the next record loads as the final byte leaves,
   // so instructions stream with no gap cycles.
   x86mov_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hw/rtl/x86mov_checker.sv =====
// Port-level assertions for the MOV encoder and the bind that attaches them.
`include "x86_64_mov_encoder_macros.svh"

module x86mov_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Byte position within the current instruction.
   logic [3:0] pos_ff, pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && rsp_ready) begin
         pos_in = rsp_last ? 4'd0 : pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `X86MOV_ASSERT_ALWAYS(a_idle_after_reset, (reset |=> !rsp_valid), "byte valid right after reset")
   `X86MOV_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)), "stalled byte changed")
   `X86MOV_ASSERT(a_rex_first, (rsp_valid && pos_ff == 4'd0 |-> rsp_out_byte[7:3] == 5'b01001), "first byte is not REX.W")
   `X86MOV_ASSERT(a_len_min, (rsp_valid && pos_ff <= 4'd1 |-> !rsp_last), "instruction shorter than 3 bytes")
   `X86MOV_ASSERT(a_len_max, (rsp_valid && pos_ff == 4'd9 |-> rsp_last), "instruction longer than 10 bytes")

endmodule

bind x86_64_mov_encoder x86mov_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

// ===== verif/tb_x86_64_mov_encoder.sv =====
// Self-checking testbench for the x86-64 MOV encoder: directed table, then random requests.
module tb_x86_64_mov_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape
   localparam int unsigned RANDOM_REQUESTS = 350;
   localparam int unsigned HOLD_CYCLES     = 300;   // one long stall on the byte side
   localparam int unsigned HOLD_AFTER      = 40;    // start the long stall after this many requests
   localparam int unsigned IDLE_LIMIT      = 3000;  // cycles with no transaction on either side
   localparam int unsigned DRAIN_CYCLES    = 32;    // quiet time after the last byte
   localparam int unsigned REPORT_LIMIT    = 10;

   // REX prefix top bits: 0100 plus W set
   localparam logic [4:0] REX_W_TOP = 5'b01001;

   // One request plus, where it is obvious, its encoding typed in by hand.
   // gold holds the bytes in sending order, first byte leftmost; gold_len 0 means
   // the row is checked against the predictor instead.
   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  dst;
      logic [3:0]  src;
      logic [3:0]  base;
      logic [31:0] disp;
      logic [63:0] imm;
      logic [3:0]  gold_len;
      logic [79:0] gold;
   } mov_request_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } mov_byte_type;

   localparam int unsigned LISTED_COUNT = 23;

   // Directed table: extremes of every field, all four forms, rbp/r13 zero displacement,
   // rsp/r12 SIB byte, disp8/disp32 boundaries, imm32/imm64 boundary, ignored fields set.
   localparam mov_request_type LISTED [LISTED_COUNT] = '{
      // store rax -> [rax], no displacement
      '{x86mov_pkg::MODE_STORE, 4'd0, 4'd0, 4'd0, 32'd0, 64'd0, 4'd3, 80'h48_89_00},
      '{x86mov_pkg::MODE_STORE, 4'd3, 4'd15, 4'd15, 32'd0, 64'd0, 4'd0, 80'd0},
      // rbp base with zero displacement still takes a disp8
      '{x86mov_pkg::MODE_STORE, 4'd0, 4'd8, 4'd5, 32'd0, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_LOAD, 4'd15, 4'd0, 4'd13, 32'd0, 64'd0, 4'd4, 80'h4D_8B_7D_00},
      // rsp base, largest displacement
      '{x86mov_pkg::MODE_STORE, 4'd0, 4'd0, 4'd4, 32'h7FFF_FFFF, 64'd0, 4'd8,
        80'h48_89_84_24_FF_FF_FF_7F},
      '{x86mov_pkg::MODE_LOAD, 4'd0, 4'd0, 4'd12, 32'hFFFF_FF80, 64'd0, 4'd5,
        80'h49_8B_44_24_80},
      '{x86mov_pkg::MODE_STORE, 4'd0, 4'd9, 4'd3, 32'd127, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_LOAD, 4'd6, 4'd0, 4'd4, 32'd128, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_LOAD, 4'd10, 4'd0, 4'd5, 32'hFFFF_FF7F, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_STORE, 4'd0, 4'd12, 4'd12, 32'h8000_0000, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_LOAD, 4'd1, 4'd0, 4'd4, 32'hFFFF_FFFF, 64'd0, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_LOAD, 4'd2, 4'd15, 4'd12, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
        4'd0, 80'd0},
      '{x86mov_pkg::MODE_REG, 4'd15, 4'd15, 4'd0, 32'd0, 64'd0, 4'd3, 80'h4D_89_FF},
      '{x86mov_pkg::MODE_REG, 4'd0, 4'd0, 4'd0, 32'd0, 64'd0, 4'd3, 80'h48_89_C0},
      '{x86mov_pkg::MODE_REG, 4'd3, 4'd8, 4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        4'd0, 80'd0},
      '{x86mov_pkg::MODE_IMM, 4'd0, 4'd0, 4'd0, 32'd0, 64'd0, 4'd7,
        80'h48_C7_C0_00_00_00_00},
      // largest value that still fits the sign-extended imm32 form
      '{x86mov_pkg::MODE_IMM, 4'd0, 4'd0, 4'd0, 32'd0, 64'h7FFF_FFFF, 4'd7,
        80'h48_C7_C0_FF_FF_FF_7F},
      '{x86mov_pkg::MODE_IMM, 4'd8, 4'd0, 4'd0, 32'd0, 64'h8000_0000, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_IMM, 4'd15, 4'd0, 4'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd10,
        80'h49_BF_FF_FF_FF_FF_FF_FF_FF_FF},
      '{x86mov_pkg::MODE_IMM, 4'd7, 4'd0, 4'd0, 32'd0, 64'h8000_0000_0000_0000,
        4'd0, 80'd0},
      '{x86mov_pkg::MODE_IMM, 4'd12, 4'd0, 4'd0, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF,
        4'd0, 80'd0},
      '{x86mov_pkg::MODE_IMM, 4'd13, 4'd15, 4'd15, 32'hFFFF_FFFF, 64'd1, 4'd0, 80'd0},
      '{x86mov_pkg::MODE_STORE, 4'd15, 4'd7, 4'd8, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        4'd0, 80'd0}
   };

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // Request side
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode         = '0;
   logic [3:0]         req_dst_reg      = '0;
   logic [3:0]         req_src_reg      = '0;
   logic [3:0]         req_base_reg     = '0;
   logic signed [31:0] req_displacement = '0;
   logic signed [63:0] req_immediate    = '0;

   // Byte side
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last;

   // Scoreboard state
   mov_byte_type expected_bytes [$];
   int unsigned  fail_count     = 0;
   int unsigned  requests_taken = 0;
   int unsigned  quiet_cycles   = 0;
   bit           calm_phase     = 1'b0;   // no random idles on either side while set
   bit           sink_holding   = 1'b0;   // byte side is in its long stall

   x86_64_mov_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_dst_reg      (req_dst_reg),
      .req_src_reg      (req_src_reg),
      .req_base_reg     (req_base_reg),
      .req_displacement (req_displacement),
      .req_immediate    (req_immediate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t ns: MISMATCH %s", $time, what);
   endfunction

   // Idle length: mostly none or short, now and then long; none at all in calm stretches
   // or while the byte side holds off (keeps the sender pushing into a full queue).
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || sink_holding) return 0;
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Expected bytes of one MOV, built form by form.
   function automatic void encode_mov(input mov_request_type r);
      logic [7:0]         seq [x86mov_pkg::MAX_BYTES];
      int unsigned        n;
      logic [3:0]         reg_f;
      logic [1:0]         mod_f;
      logic signed [31:0] sdisp;
      mov_byte_type       item;
      n     = 0;
      sdisp = r.disp;
      mod_f = x86mov_pkg::MOD_NODISP;
      case (r.mode)
         x86mov_pkg::MODE_STORE, x86mov_pkg::MODE_LOAD: begin
            reg_f = (r.mode == x86mov_pkg::MODE_STORE) ? r.src : r.dst;
            // rbp/r13 have no no-displacement encoding, so a zero goes out as disp8
            if (r.disp == '0 && r.base[2:0] != x86mov_pkg::RM_RIPBP)
               mod_f = x86mov_pkg::MOD_NODISP;
            else if (sdisp >= -128 && sdisp <= 127)
               mod_f = x86mov_pkg::MOD_DISP8;
            else
               mod_f = x86mov_pkg::MOD_DISP32;
            seq[0] = {REX_W_TOP, reg_f[3], 1'b0, r.base[3]};
            seq[1] = (r.mode == x86mov_pkg::MODE_STORE) ? x86mov_pkg::OPC_MOV_STORE
                                                        : x86mov_pkg::OPC_MOV_LOAD;
            seq[2] = {mod_f, reg_f[2:0], r.base[2:0]};
            n = 3;
            // rsp/r12 as base needs a SIB byte
            if (r.base[2:0] == x86mov_pkg::RM_SIB) begin
               seq[n] = x86mov_pkg::SIB_NO_INDEX;
               n++;
            end
            if (mod_f == x86mov_pkg::MOD_DISP8) begin
               seq[n] = r.disp[7:0];
               n++;
            end else if (mod_f == x86mov_pkg::MOD_DISP32) begin
               for (int i = 0; i < 4; i++) begin
                  seq[n] = r.disp[8*i +: 8];
                  n++;
               end
            end
         end
         x86mov_pkg::MODE_REG: begin
            seq[0] = {REX_W_TOP, r.src[3], 1'b0, r.dst[3]};
            seq[1] = x86mov_pkg::OPC_MOV_STORE;
            seq[2] = {x86mov_pkg::MOD_DIRECT, r.src[2:0], r.dst[2:0]};
            n = 3;
         end
         default: begin
            seq[0] = {REX_W_TOP, 1'b0, 1'b0, r.dst[3]};
            // imm32 form sign-extends, so only 0..7FFFFFFF may use it
            if (r.imm[63:31] == '0) begin
               seq[1] = x86mov_pkg::OPC_MOV_IMM32;
               seq[2] = {x86mov_pkg::MOD_DIRECT, 3'b000, r.dst[2:0]};
               n = 3;
               for (int i = 0; i < 4; i++) begin
                  seq[n] = r.imm[8*i +: 8];
                  n++;
               end
            end else begin
               seq[1] = x86mov_pkg::OPC_MOV_IMM64 + {5'b00000, r.dst[2:0]};
               n = 2;
               for (int i = 0; i < 8; i++) begin
                  seq[n] = r.imm[8*i +: 8];
                  n++;
               end
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         item.value = seq[i];
         item.last  = (i == n - 1);
         expected_bytes.push_back(item);
      end
   endfunction

   // Queue the expectation of an accepted request: hand-typed bytes where given.
   function automatic void queue_expected(input mov_request_type r);
      mov_byte_type item;
      int           len;
      len = r.gold_len;
      if (len == 0) begin
         encode_mov(r);
      end else begin
         for (int i = 0; i < len; i++) begin
            item.value = r.gold[8*(len-1-i) +: 8];
            item.last  = (i == len - 1);
            expected_bytes.push_back(item);
         end
      end
   endfunction

   // Random request: every field random, with displacement and immediate biased
   // toward the form boundaries.
   function automatic mov_request_type random_request();
      mov_request_type r;
      r      = '0;
      r.mode = 2'($urandom_range(0, 3));
      r.dst  = 4'($urandom_range(0, 15));
      r.src  = 4'($urandom_range(0, 15));
      r.base = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 5))
         0: r.disp = '0;
         1: r.disp = $urandom_range(0, 255) - 128;
         2: begin
            case ($urandom_range(0, 3))
               0: r.disp = 32'd127;
               1: r.disp = 32'd128;
               2: r.disp = 32'hFFFF_FF80;
               default: r.disp = 32'hFFFF_FF7F;
            endcase
         end
         default: r.disp = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0: r.imm = {32'd0, 1'b0, 31'($urandom)};
         1: begin
            case ($urandom_range(0, 4))
               0: r.imm = 64'd0;
               1: r.imm = 64'h7FFF_FFFF;
               2: r.imm = 64'h8000_0000;
               3: r.imm = 64'hFFFF_FFFF_FFFF_FFFF;
               default: r.imm = 64'h8000_0000_0000_0000;
            endcase
         end
         2: r.imm = {32'hFFFF_FFFF, 32'($urandom)};
         default: r.imm = {32'($urandom), 32'($urandom)};
      endcase
      return r;
   endfunction

   // Offer one request from the falling edge on and hold it until taken, then idle a while.
   // Fields carry noise while valid is low.
   task automatic offer(input mov_request_type r);
      int unsigned     gap;
      mov_request_type noise;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_mode         <= r.mode;
      req_dst_reg      <= r.dst;
      req_src_reg      <= r.src;
      req_base_reg     <= r.base;
      req_displacement <= r.disp;
      req_immediate    <= r.imm;
      do @(posedge clock); while (!req_ready);
      queue_expected(r);
      requests_taken++;
      gap = pick_gap();
      if (gap != 0) begin
         noise = random_request();
         @(negedge clock);
         req_valid        <= 1'b0;
         req_mode         <= noise.mode;
         req_dst_reg      <= noise.dst;
         req_src_reg      <= noise.src;
         req_base_reg     <= noise.base;
         req_displacement <= noise.disp;
         req_immediate    <= noise.imm;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stimulus and end of run
   initial begin : request_side
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < LISTED_COUNT; i++)
         offer(LISTED[i]);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // switch between calm stretches and idling stretches now and then
         if (i % 50 == 0)
            calm_phase = ($urandom_range(0, 2) == 0);
         offer(random_request());
      end
      calm_phase = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // wait out every byte, then a little longer for strays; the watchdog bounds this
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Byte side ready: random stalls, plus one long hold so the record queue fills up
   // and the request side backs up.
   initial begin : byte_sink
      int unsigned stall;
      bit          held;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && requests_taken >= HOLD_AFTER) begin
            held         = 1'b1;
            sink_holding = 1'b1;
            rsp_ready   <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            sink_holding = 1'b0;
            rsp_ready   <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // Each byte transaction against the oldest expected byte, field by field
   always @(posedge clock) begin : byte_check
      mov_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            note_failure($sformatf("unexpected byte %02h last %0b", rsp_out_byte, rsp_last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.value)
               note_failure($sformatf("out_byte expected %02h got %02h",
                                      want.value, rsp_out_byte));
            if (rsp_last !== want.last)
               note_failure($sformatf("last expected %0b got %0b (byte %02h)",
                                      want.last, rsp_last, want.value));
         end
      end
   end

   // Watchdog: too long without a transaction on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/x86mov_pkg.sv
hw/rtl/x86mov_front.sv
hw/rtl/x86mov_queue.sv
hw/rtl/x86mov_back.sv
hw/rtl/x86_64_mov_encoder.sv
hw/rtl/x86mov_checker.sv
verif/tb_x86_64_mov_encoder.sv
